@@ sv/assert_macros.svh @@
// Assertion macros for the coordinate sorter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/scsml_pkg.sv @@
// Types, constants and the sort-key compare for the coordinate sorter.
`timescale 1ns / 1ps
`default_nettype none
package scsml_pkg;

  localparam int MAX_ELEMS   = 64;
  localparam int MAX_MODES   = 4;
  localparam int COORD_WIDTH = 32;
  localparam int VALUE_WIDTH = 32;

  localparam int FILL_W = $clog2(MAX_ELEMS + 1);
  localparam int PASS_W = $clog2(MAX_ELEMS);
  localparam int NM_W   = $clog2(MAX_MODES + 1);

  // Configuration register widths and indexes
  localparam int MC_W       = 3;
  localparam int LM_W       = 2;
  localparam int CFG_DATA_W = 3;
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MODE_COUNT = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_MODE  = 1'd1;
  localparam logic [MC_W-1:0] MODE_COUNT_RST = 3'd3;
  localparam logic [LM_W-1:0] LAST_MODE_RST  = 2'd0;

  typedef struct packed {
    logic [31:0] coord_0;
    logic [31:0] coord_1;
    logic [31:0] coord_2;
    logic [31:0] coord_3;
    logic [31:0] elem_value;
    logic        is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_coord_0;
    logic [31:0] out_coord_1;
    logic [31:0] out_coord_2;
    logic [31:0] out_coord_3;
    logic [31:0] out_value;
    logic        out_last;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic [MAX_MODES-1:0][COORD_WIDTH-1:0] coord;
    logic [VALUE_WIDTH-1:0]                value;
  } elem_t;

  typedef struct packed {
    logic  valid;
    elem_t elem;
  } cell_data_t;

  typedef struct packed {
    logic [NM_W-1:0] nm;
    logic [LM_W-1:0] lm;
    logic            use_last;
  } key_cfg_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_SORT_LO,
    CELL_SORT_HI
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

  // True when a orders strictly after b under the key.
  function automatic logic key_gt(input elem_t a, input elem_t b, input key_cfg_t k);
    logic done;
    logic gt;
    done = 1'b0;
    gt   = 1'b0;
    for (int m = 0; m < MAX_MODES; m++) begin
      if (!done && (m < int'(k.nm)) && !(k.use_last && (m == int'(k.lm)))) begin
        if (a.coord[m] != b.coord[m]) begin
          gt   = (a.coord[m] > b.coord[m]);
          done = 1'b1;
        end
      end
    end
    if (!done && k.use_last) begin
      gt = (a.coord[k.lm] > b.coord[k.lm]);
    end
    return gt;
  endfunction

endpackage
`default_nettype wire

@@ sv/scsml_cell.sv @@
// One cell of the sort chain: holds an element, shifts or compare-exchanges.
`timescale 1ns / 1ps
`default_nettype none
module scsml_cell
  import scsml_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cell_ctl_t  ctl,
  input  wire key_cfg_t   key,
  input  wire cell_data_t up_data,
  input  wire cell_data_t dn_data,
  input  wire logic       dn_swap,
  output cell_data_t      data,
  output logic            swap_up
);

  cell_data_t data_r;
  cell_data_t data_nxt;

  // Empty cells order below every element, so they sink to the low end.
  assign swap_up = data_r.valid &&
                   (!up_data.valid || key_gt(data_r.elem, up_data.elem, key));

  always_comb begin
    data_nxt = data_r;
    case (ctl.op)
      CELL_SHIFT:   data_nxt = up_data;
      CELL_SORT_LO: if (swap_up) data_nxt = up_data;
      CELL_SORT_HI: if (dn_swap) data_nxt = dn_data;
      default:      data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r.valid <= 1'b0;
    end else begin
      data_r.valid <= data_nxt.valid;
    end
    data_r.elem <= data_nxt.elem;
  end

  assign data = data_r;

endmodule
`default_nettype wire

@@ sv/sparse_coord_sort_mode_last.sv @@
// Load: one word per cycle, entering at the top cell of a 64-cell chain.
// After the closing word: odd-even compare-exchange passes over the chain, then empty cells
// leave the bottom until the first sorted word is valid there.
// Then one word per cycle while out_stall is low; a set holds the block until its last word is taken.
// Reset (synchronous, rst_n low): chain empty, counts and overflow cleared,
// mode_count = 3, last_mode = 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sparse_coord_sort_mode_last
  import scsml_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_DRAIN
  } state_t;

  state_t            state_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] left_r;
  logic [PASS_W-1:0] pass_r;
  logic              ovf_r;
  key_cfg_t          key_r;
  logic [MC_W-1:0]   mode_count_r;
  logic [LM_W-1:0]   last_mode_r;

  cell_data_t cell_q    [MAX_ELEMS];
  logic       cell_swap [MAX_ELEMS];
  cell_data_t top_in;
  key_cfg_t   key_nxt;
  logic       in_acc;
  logic       out_acc;
  logic       run_end;
  logic       shift_all;
  logic       do_sort;
  logic [NM_W-1:0] nm_eff;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == ST_DRAIN) && cell_q[0].valid;
  assign out_acc   = out_valid && !out_stall;
  assign run_end   = out_acc && out_data.out_last;

  // Shift on a stored load word, on an output word taken, or to drop an empty bottom cell.
  assign shift_all = (in_acc && (fill_r < FILL_W'(MAX_ELEMS))) ||
                     ((state_r == ST_DRAIN) && (!cell_q[0].valid || !out_stall));
  assign do_sort   = (state_r == ST_SORT);

  always_comb begin
    top_in.valid         = (state_r == ST_LOAD);
    top_in.elem.coord[0] = COORD_WIDTH'(in_data.coord_0);
    top_in.elem.coord[1] = COORD_WIDTH'(in_data.coord_1);
    top_in.elem.coord[2] = COORD_WIDTH'(in_data.coord_2);
    top_in.elem.coord[3] = COORD_WIDTH'(in_data.coord_3);
    top_in.elem.value    = in_data.elem_value;
  end

  // Clamp the mode count into 1..MAX_MODES
  always_comb begin
    if (mode_count_r == '0) begin
      nm_eff = NM_W'(1);
    end else if (int'(mode_count_r) > MAX_MODES) begin
      nm_eff = NM_W'(MAX_MODES);
    end else begin
      nm_eff = NM_W'(mode_count_r);
    end
    key_nxt.nm       = nm_eff;
    key_nxt.lm       = last_mode_r;
    key_nxt.use_last = (int'(last_mode_r) < int'(nm_eff));
  end

  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    localparam bit ODD = (i % 2) == 1;
    cell_ctl_t  ctl;
    cell_data_t up_d;
    cell_data_t dn_d;
    logic       dn_sw;

    if (i < MAX_ELEMS - 1) begin : g_up
      assign up_d = cell_q[i+1];
    end else begin : g_top
      assign up_d = top_in;
    end

    if (i > 0) begin : g_dn
      assign dn_d  = cell_q[i-1];
      assign dn_sw = cell_swap[i-1];
    end else begin : g_bot
      assign dn_d  = '0;
      assign dn_sw = 1'b0;
    end

    // Even passes pair (0,1),(2,3)..; odd passes pair (1,2),(3,4)..
    always_comb begin
      ctl.op = CELL_HOLD;
      if (shift_all) begin
        ctl.op = CELL_SHIFT;
      end else if (do_sort) begin
        if ((ODD == pass_r[0]) && (i < MAX_ELEMS - 1)) begin
          ctl.op = CELL_SORT_LO;
        end else if ((ODD != pass_r[0]) && (i > 0)) begin
          ctl.op = CELL_SORT_HI;
        end
      end
    end

    scsml_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .key     (key_r),
      .up_data (up_d),
      .dn_data (dn_d),
      .dn_swap (dn_sw),
      .data    (cell_q[i]),
      .swap_up (cell_swap[i])
    );
  end

  always_comb begin
    out_data.out_coord_0 = 32'(cell_q[0].elem.coord[0]);
    out_data.out_coord_1 = 32'(cell_q[0].elem.coord[1]);
    out_data.out_coord_2 = 32'(cell_q[0].elem.coord[2]);
    out_data.out_coord_3 = 32'(cell_q[0].elem.coord[3]);
    out_data.out_value   = cell_q[0].elem.value;
    out_data.out_last    = (left_r == FILL_W'(1));
    out_data.overflow    = ovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      fill_r       <= '0;
      left_r       <= '0;
      pass_r       <= '0;
      ovf_r        <= 1'b0;
      key_r        <= '0;
      mode_count_r <= MODE_COUNT_RST;
      last_mode_r  <= LAST_MODE_RST;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_MODE_COUNT: mode_count_r <= cfg_data[MC_W-1:0];
          CFG_LAST_MODE:  last_mode_r  <= cfg_data[LM_W-1:0];
          default:        ;
        endcase
      end
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (fill_r < FILL_W'(MAX_ELEMS)) begin
              fill_r <= fill_r + FILL_W'(1);
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_data.is_last) begin
              key_r   <= key_nxt;
              pass_r  <= '0;
              state_r <= ST_SORT;
            end
          end
        end
        ST_SORT: begin
          pass_r <= pass_r + PASS_W'(1);
          if (pass_r == PASS_W'(MAX_ELEMS - 1)) begin
            left_r  <= fill_r;
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_acc) begin
            left_r <= left_r - FILL_W'(1);
            if (left_r == FILL_W'(1)) begin
              fill_r  <= '0;
              ovf_r   <= 1'b0;
              state_r <= ST_LOAD;
            end
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_has_left, out_valid, left_r != '0, "output word with no element left")
  `ASSERT_ALWAYS(a_fill_bound, fill_r <= FILL_W'(MAX_ELEMS), "fill count beyond capacity")
  `ASSERT_NEXT(a_close_sorts, in_acc && in_data.is_last, state_r == ST_SORT, "no sort on close")
  `ASSERT_NEXT(a_run_clears, run_end, (fill_r == '0) && !ovf_r, "run end kept set state")
  `ASSERT_NEXT(a_run_reloads, run_end, state_r == ST_LOAD, "run end did not reload")

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the lexicographic coordinate sorter with a selectable last mode.
`timescale 1ns / 1ps
module tb;
  import scsml_pkg::*;

  typedef struct {
    bit        set_cfg;
    bit [2:0]  mc;
    bit [1:0]  lm;
    in_item_t  w;
    bit        typed;
    out_item_t exp;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n    = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we   = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: words of the open set, overflow flag, register copies
  in_item_t  set_words[$];
  bit        set_dropped;
  bit [2:0]  mode_reg = MODE_COUNT_RST;
  bit [1:0]  last_reg = LAST_MODE_RST;
  out_item_t sorted_due[$];

  stim_row_t script[$];
  int        errors   = 0;
  bit        in_calm  = 1'b0;
  bit        out_calm = 1'b0;
  int        stall_run = 0;

  sparse_coord_sort_mode_last u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sparse_coord_sort_mode_last regression: fail");
    $finish;
  end

  function automatic bit [31:0] coord_of(in_item_t w, int m);
    case (m)
      0: return w.coord_0;
      1: return w.coord_1;
      2: return w.coord_2;
      3: return w.coord_3;
      default: return 32'd0;
    endcase
  endfunction

  // True when a must come strictly after b under the current key.
  function automatic bit orders_after(in_item_t a, in_item_t b, int nm, int lm, bit use_last);
    bit [31:0] x;
    bit [31:0] y;
    for (int m = 0; m < nm; m++) begin
      if (!(use_last && m == lm)) begin
        x = coord_of(a, m);
        y = coord_of(b, m);
        if (x != y) return x > y;
      end
    end
    if (use_last) begin
      x = coord_of(a, lm);
      y = coord_of(b, lm);
      return x > y;
    end
    return 1'b0;
  endfunction

  // Store one accepted word; on the closing word, sort the set and queue the run.
  function automatic void store_word(in_item_t w);
    in_item_t  s[$];
    in_item_t  cur;
    out_item_t o;
    int        nm;
    int        lm;
    bit        use_last;
    int        j;
    if (set_words.size() < MAX_ELEMS) set_words.push_back(w);
    else set_dropped = 1'b1;
    if (!w.is_last) return;
    nm = mode_reg;
    if (nm < 1) nm = 1;
    if (nm > MAX_MODES) nm = MAX_MODES;
    lm = last_reg;
    use_last = (lm < nm);
    s = set_words;
    // Insertion sort keeps equal keys in load order
    for (int i = 1; i < s.size(); i++) begin
      cur = s[i];
      j = i;
      while (j > 0 && orders_after(s[j-1], cur, nm, lm, use_last)) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = cur;
    end
    foreach (s[i]) begin
      o.out_coord_0 = s[i].coord_0;
      o.out_coord_1 = s[i].coord_1;
      o.out_coord_2 = s[i].coord_2;
      o.out_coord_3 = s[i].coord_3;
      o.out_value   = s[i].elem_value;
      o.out_last    = (i == s.size() - 1);
      o.overflow    = set_dropped;
      sorted_due.push_back(o);
    end
    set_words.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void add_row(bit set_cfg, bit [2:0] mc, bit [1:0] lm, in_item_t w,
                                  bit typed, out_item_t exp);
    stim_row_t r;
    r.set_cfg = set_cfg;
    r.mc      = mc;
    r.lm      = lm;
    r.w       = w;
    r.typed   = typed;
    r.exp     = exp;
    script.push_back(r);
  endfunction

  function automatic int idle_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit [31:0] pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 3);
    if (r < 85) return $urandom();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h0000_0001;
      default: return 32'hFFFF_FFFE;
    endcase
  endfunction

  function automatic in_item_t rand_word(bit closing);
    in_item_t w;
    w.coord_0    = pick_coord();
    w.coord_1    = pick_coord();
    w.coord_2    = pick_coord();
    w.coord_3    = pick_coord();
    w.elem_value = $urandom();
    w.is_last    = closing;
    return w;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Hold the word until taken, then update the prediction and idle a while.
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t exp);
    int gap;
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    store_word(w);
    if (typed) begin
      void'(sorted_due.pop_back());
      sorted_due.push_back(exp);
    end
    gap = idle_len(in_calm);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain every pending result, let the block settle, then write both registers.
  task automatic program_regs(input bit [2:0] mc, input bit [1:0] lm);
    in_valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_MODE_COUNT;
    cfg_data <= mc;
    @(posedge clk);
    cfg_addr <= CFG_LAST_MODE;
    cfg_data <= {1'b0, lm};
    @(posedge clk);
    cfg_we   <= 1'b0;
    mode_reg = mc;
    last_reg = lm;
  endtask

  // Receiver stall: short bursts mostly, an occasional long hold, calm stretches.
  always @(posedge clk) begin : stall_gen
    int r;
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (out_calm || r < 55) begin
        out_stall <= 1'b0;
        stall_run <= $urandom_range(0, 6);
      end else if (r < 92) begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b1;
        stall_run <= $urandom_range(10, 60);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual %h", $time, out_data);
        errors++;
      end else begin
        want = sorted_due.pop_front();
        check_field("out_coord_0", want.out_coord_0, out_data.out_coord_0);
        check_field("out_coord_1", want.out_coord_1, out_data.out_coord_1);
        check_field("out_coord_2", want.out_coord_2, out_data.out_coord_2);
        check_field("out_coord_3", want.out_coord_3, out_data.out_coord_3);
        check_field("out_value", want.out_value, out_data.out_value);
        check_field("out_last", 32'(want.out_last), 32'(out_data.out_last));
        check_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
      end
    end
  end

  initial begin : stimulus
    int rnd_words;
    int set_no;
    int set_len;
    int r;

    // Reset register values: single-word sets echo the word back
    add_row(0, 3'd3, 2'd0, {{5{32'hFFFF_FFFF}}, 1'b1}, 1, {{5{32'hFFFF_FFFF}}, 1'b1, 1'b0});
    add_row(0, 3'd3, 2'd0, {{5{32'h0}}, 1'b1}, 1, {{5{32'h0}}, 1'b1, 1'b0});
    // Three modes, mode 0 decides last; mode 3 carried but not compared
    add_row(1, 3'd3, 2'd0, {32'd5, 32'd1, 32'd1, 32'd9, 32'h100, 1'b0}, 0, '0);
    add_row(0, 3'd3, 2'd0, {32'd2, 32'd1, 32'd1, 32'd7, 32'h101, 1'b0}, 0, '0);
    add_row(0, 3'd3, 2'd0, {32'd9, 32'd0, 32'd4, 32'd0, 32'h102, 1'b0}, 0, '0);
    add_row(0, 3'd3, 2'd0, {32'd1, 32'd1, 32'd0, 32'd3, 32'h103, 1'b1}, 0, '0);
    // Mode count zero acts as one; equal keys keep load order
    add_row(1, 3'd0, 2'd0, {32'd7, 32'd1, 32'd2, 32'd3, 32'hA, 1'b0}, 0, '0);
    add_row(0, 3'd0, 2'd0, {32'd3, 32'd9, 32'd9, 32'd9, 32'hB, 1'b0}, 0, '0);
    add_row(0, 3'd0, 2'd0, {32'd7, 32'd0, 32'd0, 32'd0, 32'hC, 1'b0}, 0, '0);
    add_row(0, 3'd0, 2'd0, {32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'hD, 1'b1}, 0, '0);
    // Mode count above four clips to four; last mode is mode 3
    add_row(1, 3'd7, 2'd3, {32'd1, 32'd2, 32'd3, 32'd4, 32'h20, 1'b0}, 0, '0);
    add_row(0, 3'd7, 2'd3, {32'd1, 32'd2, 32'd3, 32'd0, 32'h21, 1'b0}, 0, '0);
    add_row(0, 3'd7, 2'd3, {32'd1, 32'd2, 32'd0, 32'd9, 32'h22, 1'b0}, 0, '0);
    add_row(0, 3'd7, 2'd3, {32'd0, {3{32'hFFFF_FFFF}}, 32'h23, 1'b1}, 0, '0);
    // Last mode outside the modes in use: plain order over modes 0 and 1
    add_row(1, 3'd2, 2'd3, {32'd4, 32'd4, 32'd1, 32'd1, 32'h30, 1'b0}, 0, '0);
    add_row(0, 3'd2, 2'd3, {32'd4, 32'd4, 32'd0, 32'd0, 32'h31, 1'b0}, 0, '0);
    add_row(0, 3'd2, 2'd3, {32'd4, 32'd3, 32'd9, 32'd9, 32'h32, 1'b0}, 0, '0);
    add_row(0, 3'd2, 2'd3, {32'd0, 32'd5, 32'd7, 32'd7, 32'h33, 1'b1}, 0, '0);
    // Four modes, mode 2 last, alternating bit patterns
    add_row(1, 3'd4, 2'd2, {{2{32'hAAAA_AAAA, 32'h5555_5555}}, 32'h5555_5555, 1'b0}, 0, '0);
    add_row(0, 3'd4, 2'd2, {{2{32'h5555_5555, 32'hAAAA_AAAA}}, 32'hAAAA_AAAA, 1'b0}, 0, '0);
    add_row(0, 3'd4, 2'd2, {32'hAAAA_AAAA, 32'h5555_5555, 32'd0, 32'h5555_5555, 32'h1, 1'b1},
            0, '0);
    // One mode in use, last mode 1 not in use
    add_row(1, 3'd1, 2'd1, {32'd8, 32'd1, 32'd1, 32'd1, 32'h40, 1'b0}, 0, '0);
    add_row(0, 3'd1, 2'd1, {32'd8, 32'd0, 32'd0, 32'd0, 32'h41, 1'b1}, 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[k]) begin
      if (script[k].set_cfg) program_regs(script[k].mc, script[k].lm);
      send_word(script[k].w, script[k].typed, script[k].exp);
    end

    rnd_words = 0;
    set_no    = 0;
    while (rnd_words < 260) begin
      in_calm  = ($urandom_range(0, 4) == 0);
      out_calm = ($urandom_range(0, 4) == 0);
      if (set_no == 0 || $urandom_range(0, 2) == 0)
        program_regs($urandom_range(0, 7), $urandom_range(0, 3));
      // Force one set past capacity and one that fills it exactly
      r = $urandom_range(0, 99);
      if (set_no == 2) set_len = MAX_ELEMS + 3;
      else if (set_no == 4) set_len = MAX_ELEMS;
      else if (r < 70) set_len = $urandom_range(1, 8);
      else if (r < 92) set_len = $urandom_range(9, 24);
      else if (r < 97) set_len = $urandom_range(25, 40);
      else set_len = $urandom_range(MAX_ELEMS + 1, MAX_ELEMS + 6);
      for (int i = 0; i < set_len; i++) send_word(rand_word(i == set_len - 1), 0, '0);
      rnd_words += set_len;
      set_no++;
    end

    in_valid <= 1'b0;
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("sparse_coord_sort_mode_last regression: pass");
    end else begin
      $display("sparse_coord_sort_mode_last regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/scsml_pkg.sv
sv/scsml_cell.sv
sv/sparse_coord_sort_mode_last.sv
tb/sv/tb.sv
